FILE: rtl/mconv_pkg.sv
// shared types, codes and helpers for the multichannel convolution block
package mconv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int FIELD_LANES = 4;

    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_WEIGHT = 2'd1;
    localparam logic [1:0] MODE_BIAS   = 2'd2;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_IN_CHANNELS  = 3'd2;
    localparam logic [2:0] REG_OUT_CHANNELS = 3'd3;
    localparam logic [2:0] REG_KERNEL_ROWS  = 3'd4;
    localparam logic [2:0] REG_KERNEL_COLS  = 3'd5;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         entry_index;
        logic signed [15:0] weight_value;
        logic signed [31:0] bias_value;
        logic               first_pixel;
        logic signed [15:0] sample_0;
        logic signed [15:0] sample_1;
        logic signed [15:0] sample_2;
        logic signed [15:0] sample_3;
    } conv_in_t;

    typedef struct packed {
        logic [2:0]         out_channel;
        logic [7:0]         out_row;
        logic [7:0]         out_col;
        logic signed [31:0] out_value;
        logic               last;
    } conv_out_t;

    // per-tap control that travels along the lane pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tap_ctl_t;

    function automatic int clamp_cfg(input int v, input int hi);
        int r;
        r = v;
        if (v < 1) r = 1;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

FILE: rtl/mconv_ram.sv
// generic simple dual-port ram with registered read
module mconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mconv_lane.sv
// one input-channel lane: weight memory and multiplier
module mconv_lane
    import mconv_pkg::*;
#(
    parameter int LANE   = 0,
    parameter int KSQ    = 25,
    parameter int WDEPTH = 800
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [$clog2(WDEPTH)-1:0]         waddr,
    input  logic signed [SAMPLE_W-1:0]        wdata,
    input  logic                              en,
    input  logic [$clog2(WDEPTH)-1:0]         tap_addr,
    input  logic signed [SAMPLE_W-1:0]        sample,
    input  logic                              lane_on,
    output logic signed [PROD_W-1:0]          product
);

    localparam int WAW = $clog2(WDEPTH);

    logic [WAW-1:0]             raddr;
    logic [SAMPLE_W-1:0]        wrd;
    logic signed [PROD_W-1:0]   product_reg;

    // every lane holds the full weight set and reads its own channel slice
    assign raddr = WAW'(int'(tap_addr) + LANE * KSQ);

    mconv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WDEPTH)
    ) u_wram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (en),
        .raddr (raddr),
        .rdata (wrd)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= lane_on ? PROD_W'($signed(wrd) * sample) : '0;
        end
    end

    assign product = product_reg;

endmodule

FILE: rtl/mconv_merge.sv
// merges lane products and accumulates one output channel
module mconv_merge
    import mconv_pkg::*;
#(
    parameter int IN_LANES = 4,
    parameter int ACC_W    = 39
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  tap_ctl_t                         ctl,
    input  logic signed [PROD_W-1:0]         products [IN_LANES],
    output logic                             fin_valid,
    output logic signed [ACC_W-1:0]          fin_acc
);

    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] acc_now;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] fin_acc_reg;
    logic                    fin_valid_reg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < IN_LANES; i++) begin
            sum = sum + ACC_W'(products[i]);
        end
        acc_now = (ctl.first ? '0 : acc_reg) + sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= ctl.valid && ctl.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && ctl.valid) begin
            acc_reg <= acc_now;
            if (ctl.last) begin
                fin_acc_reg <= acc_now;
            end
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_acc   = fin_acc_reg;

endmodule

FILE: rtl/multichannel_conv2d_forward.sv
// top level: valid 2d convolution layer with bias over streamed pixels
//
// Weight and bias beats load the stores, but are taken only once no kernel
// tap is in flight. Pixel beats arrive in raster order; each is written to a
// line store of MAX_KERNEL rows. A pixel that completes a valid window holds
// off the input while out_channels * kernel_rows * kernel_cols taps are issued
// (up to 200 taps with eight output channels and a 5x5 kernel), one kernel
// tap per cycle, with the input channels handled side by side by IN_LANES
// multiplier lanes and summed in a merge stage; other pixels do not hold off
// the input. Results pass the memory read, the lane product register and the
// merge register and leave through an output register, and a result held there
// by the receiver freezes the tap sequence. After reset all MAX_KERNEL *
// MAX_WIDTH line store entries (1280 at the defaults) are cleared, during
// which no beat is taken on the input channel; configuration writes are
// accepted throughout.
module multichannel_conv2d_forward
    import mconv_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_KERNEL = 5,
    parameter int IN_LANES   = 4,
    parameter int MAX_OUT    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  conv_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output conv_out_t   m_data
);

    localparam int KSQ    = MAX_KERNEL * MAX_KERNEL;
    localparam int WDEPTH = MAX_OUT * IN_LANES * KSQ;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int LDEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CNW    = $clog2(MAX_WIDTH + 1);
    localparam int KW     = MAX_OUT > 1 ? $clog2(MAX_OUT) : 1;
    localparam int KNW    = $clog2(MAX_OUT + 1);
    localparam int KIW    = MAX_KERNEL > 1 ? $clog2(MAX_KERNEL) : 1;
    localparam int KKW    = $clog2(MAX_KERNEL + 1);
    localparam int LNW    = $clog2(IN_LANES + 1);
    localparam int ACC_W  = PROD_W + $clog2(IN_LANES * KSQ + 1);
    localparam int PIX_W  = SAMPLE_W * IN_LANES;

    typedef struct packed {
        logic [KW-1:0] k;
        logic          lastk;
        logic [7:0]    orow;
        logic [CW-1:0] ocol;
    } tap_meta_t;

    // configuration registers
    logic [8:0] width_reg, height_reg;
    logic [2:0] inch_reg;
    logic [3:0] outch_reg;
    logic [2:0] krows_reg, kcols_reg;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd32;
            height_reg <= 9'd32;
            inch_reg   <= 3'd1;
            outch_reg  <= 4'd1;
            krows_reg  <= 3'd5;
            kcols_reg  <= 3'd5;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[8:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[8:0];
                REG_IN_CHANNELS:  inch_reg   <= pwdata[2:0];
                REG_OUT_CHANNELS: outch_reg  <= pwdata[3:0];
                REG_KERNEL_ROWS:  krows_reg  <= pwdata[2:0];
                REG_KERNEL_COLS:  kcols_reg  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            REG_IN_CHANNELS:  prdata = 32'(inch_reg);
            REG_OUT_CHANNELS: prdata = 32'(outch_reg);
            REG_KERNEL_ROWS:  prdata = 32'(krows_reg);
            REG_KERNEL_COLS:  prdata = 32'(kcols_reg);
            default:          prdata = '0;
        endcase
    end

    // effective sizes
    logic [CNW-1:0] w_eff;
    logic [8:0]     h_eff;
    logic [LNW-1:0] nic_eff;
    logic [KNW-1:0] noc_eff;
    logic [KKW-1:0] kr_eff, kc_eff;

    assign w_eff   = CNW'(clamp_cfg(int'(width_reg), MAX_WIDTH));
    assign h_eff   = 9'(clamp_cfg(int'(height_reg), 256));
    assign nic_eff = LNW'(clamp_cfg(int'(inch_reg), IN_LANES));
    assign noc_eff = KNW'(clamp_cfg(int'(outch_reg), MAX_OUT));
    assign kr_eff  = KKW'(clamp_cfg(int'(krows_reg), MAX_KERNEL));
    assign kc_eff  = KKW'(clamp_cfg(int'(kcols_reg), MAX_KERNEL));

    // control state
    logic            clear_reg;
    logic [LAW-1:0]  clr_cnt_reg;
    logic [7:0]      row_reg;
    logic [CW-1:0]   col_reg;
    logic [KIW-1:0]  slot_reg;
    logic            busy_reg;
    logic [KW-1:0]   k_reg;
    logic [KIW-1:0]  a_reg, b_reg, slot_a_reg, start_reg;
    logic [7:0]      orow_reg;
    logic [CW-1:0]   ocol_reg;
    tap_ctl_t        s1_ctl_reg, s2_ctl_reg;
    tap_meta_t       s1_meta_reg, s2_meta_reg, fin_meta_reg;
    logic            out_valid_reg;
    conv_out_t       out_data_reg;
    logic signed [31:0] bias_reg [MAX_OUT];

    logic stall, fin_valid, pipe_empty, accept, pix_acc;
    logic signed [ACC_W-1:0] fin_acc;

    assign stall      = out_valid_reg && !m_ready;
    assign pipe_empty = !busy_reg && !s1_ctl_reg.valid && !s2_ctl_reg.valid && !fin_valid;
    assign s_ready    = !clear_reg && !busy_reg &&
                        (s_data.mode == MODE_PIXEL || pipe_empty);
    assign accept     = s_valid && s_ready;
    assign pix_acc    = accept && s_data.mode == MODE_PIXEL;

    // position of the incoming pixel and of the one after it
    logic [8:0]     r0, r1;
    logic [CNW-1:0] c0, c1;
    logic [KIW-1:0] s0, s1n;
    logic           win_ok;
    logic [KIW-1:0] start_slot;
    int             st;

    always_comb begin
        r0 = s_data.first_pixel ? '0 : 9'(row_reg);
        c0 = s_data.first_pixel ? '0 : CNW'(col_reg);
        s0 = s_data.first_pixel ? '0 : slot_reg;
        if (c0 >= w_eff) begin
            c0 = '0;
            r0 = r0 + 9'd1;
            s0 = (int'(s0) == MAX_KERNEL - 1) ? '0 : s0 + KIW'(1);
        end
        if (r0 >= h_eff) begin
            r0 = '0;
            s0 = '0;
        end
        win_ok = (int'(r0) + 1 >= int'(kr_eff)) && (int'(c0) + 1 >= int'(kc_eff));
        c1  = c0 + CNW'(1);
        r1  = r0;
        s1n = s0;
        if (c1 >= w_eff) begin
            c1  = '0;
            r1  = r0 + 9'd1;
            s1n = (int'(s0) == MAX_KERNEL - 1) ? '0 : s0 + KIW'(1);
            if (r1 >= h_eff) begin
                r1  = '0;
                s1n = '0;
            end
        end
        // slot of the window's top row
        st = int'(s0) + MAX_KERNEL - (int'(kr_eff) - 1);
        if (st >= MAX_KERNEL) st = st - MAX_KERNEL;
        start_slot = KIW'(st);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end else if (pix_acc) begin
            row_reg  <= r1[7:0];
            col_reg  <= CW'(c1);
            slot_reg <= s1n;
        end
    end

    // clearing pass over the line store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clear_reg) begin
            clr_cnt_reg <= clr_cnt_reg + LAW'(1);
            if (int'(clr_cnt_reg) == LDEPTH - 1) begin
                clear_reg <= 1'b0;
            end
        end
    end

    // tap sequencer
    logic issue, b_end, a_end, k_end;
    assign issue = busy_reg && !stall;
    assign b_end = int'(b_reg) == int'(kc_eff) - 1;
    assign a_end = int'(a_reg) == int'(kr_eff) - 1;
    assign k_end = int'(k_reg) == int'(noc_eff) - 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (pix_acc) begin
            busy_reg <= win_ok;
        end else if (issue && b_end && a_end && k_end) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            k_reg      <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            slot_a_reg <= start_slot;
            start_reg  <= start_slot;
            orow_reg   <= 8'(int'(r0) + 1 - int'(kr_eff));
            ocol_reg   <= CW'(int'(c0) + 1 - int'(kc_eff));
        end else if (issue) begin
            if (b_end) begin
                b_reg <= '0;
                if (a_end) begin
                    a_reg      <= '0;
                    slot_a_reg <= start_reg;
                    k_reg      <= k_reg + KW'(1);
                end else begin
                    a_reg      <= a_reg + KIW'(1);
                    slot_a_reg <= (int'(slot_a_reg) == MAX_KERNEL - 1) ? '0
                                  : slot_a_reg + KIW'(1);
                end
            end else begin
                b_reg <= b_reg + KIW'(1);
            end
        end
    end

    // pipeline control and tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end else if (!stall) begin
            s1_ctl_reg.valid <= busy_reg;
            s1_ctl_reg.first <= a_reg == '0 && b_reg == '0;
            s1_ctl_reg.last  <= a_end && b_end;
            s2_ctl_reg       <= s1_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            s1_meta_reg.k     <= k_reg;
            s1_meta_reg.lastk <= k_end;
            s1_meta_reg.orow  <= orow_reg;
            s1_meta_reg.ocol  <= ocol_reg;
            s2_meta_reg       <= s1_meta_reg;
            fin_meta_reg      <= s2_meta_reg;
        end
    end

    // line store
    logic              line_we;
    logic [LAW-1:0]    line_waddr, line_raddr;
    logic [PIX_W-1:0]  line_wdata, line_rdata, pix_vec;
    logic signed [SAMPLE_W-1:0] field_smp [FIELD_LANES];

    assign field_smp[0] = s_data.sample_0;
    assign field_smp[1] = s_data.sample_1;
    assign field_smp[2] = s_data.sample_2;
    assign field_smp[3] = s_data.sample_3;

    for (genvar i = 0; i < IN_LANES; i++) begin : g_pix
        if (i < FIELD_LANES) begin : g_field
            assign pix_vec[i*SAMPLE_W +: SAMPLE_W] = field_smp[i];
        end else begin : g_zero
            assign pix_vec[i*SAMPLE_W +: SAMPLE_W] = '0;
        end
    end

    assign line_we    = clear_reg || pix_acc;
    assign line_waddr = clear_reg ? clr_cnt_reg
                                  : LAW'(int'(s0) * MAX_WIDTH + int'(c0));
    assign line_wdata = clear_reg ? '0 : pix_vec;
    assign line_raddr = LAW'(int'(slot_a_reg) * MAX_WIDTH + int'(ocol_reg) + int'(b_reg));

    mconv_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LDEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (!stall),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // lanes
    logic                       w_we;
    logic [WAW-1:0]             w_waddr, tap_addr;
    logic signed [PROD_W-1:0]   products [IN_LANES];

    assign w_we     = accept && s_data.mode == MODE_WEIGHT &&
                      int'(s_data.entry_index) < WDEPTH;
    assign w_waddr  = WAW'(s_data.entry_index);
    assign tap_addr = WAW'(int'(k_reg) * (IN_LANES * KSQ) + int'(a_reg) * MAX_KERNEL
                           + int'(b_reg));

    for (genvar i = 0; i < IN_LANES; i++) begin : g_lane
        mconv_lane #(
            .LANE   (i),
            .KSQ    (KSQ),
            .WDEPTH (WDEPTH)
        ) u_lane (
            .aclk     (aclk),
            .we       (w_we),
            .waddr    (w_waddr),
            .wdata    (s_data.weight_value),
            .en       (!stall),
            .tap_addr (tap_addr),
            .sample   ($signed(line_rdata[i*SAMPLE_W +: SAMPLE_W])),
            .lane_on  (i < int'(nic_eff)),
            .product  (products[i])
        );
    end

    mconv_merge #(
        .IN_LANES (IN_LANES),
        .ACC_W    (ACC_W)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (!stall),
        .ctl       (s2_ctl_reg),
        .products  (products),
        .fin_valid (fin_valid),
        .fin_acc   (fin_acc)
    );

    // bias store
    always_ff @(posedge aclk) begin
        if (accept && s_data.mode == MODE_BIAS && int'(s_data.entry_index) < MAX_OUT) begin
            bias_reg[s_data.entry_index[KW-1:0]] <= s_data.bias_value;
        end
    end

    // rescale, bias and saturate into the output register
    logic signed [ACC_W:0] scaled, total;
    logic signed [31:0]    sat_val;

    always_comb begin
        scaled = (ACC_W+1)'(fin_acc) + (ACC_W+1)'(16384);
        scaled = scaled >>> 15;
        total  = scaled + (ACC_W+1)'(bias_reg[fin_meta_reg.k]);
        if (total > (ACC_W+1)'(32'sh7fffffff)) begin
            sat_val = 32'sh7fffffff;
        end else if (total < -(ACC_W+1)'(33'sh080000000)) begin
            sat_val = 32'sh80000000;
        end else begin
            sat_val = 32'(total);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!stall && fin_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && fin_valid) begin
            out_data_reg.out_channel <= 3'(fin_meta_reg.k);
            out_data_reg.out_row     <= fin_meta_reg.orow;
            out_data_reg.out_col     <= 8'(fin_meta_reg.ocol);
            out_data_reg.out_value   <= sat_val;
            out_data_reg.last        <= fin_meta_reg.lastk;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
